// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps
package pli_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SATURATED = 3'd1,
    ST_TOO_FEW   = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_W    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]   operation;
    logic [31:0]  x_value;
    logic [31:0]  y_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]  y_result;
    logic [2:0]   status;
  } out_item_t;

  localparam int QUOT_LIMIT_BITS = 62;

endpackage

// File: rtl/pli_ram.sv
`timescale 1ns / 1ps
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// Piecewise linear interpolator. A clear empties the breakpoint table, each
// append transfer stores one (x, y) point, and an evaluate transfer returns
// y at x on the first segment that holds x, extrapolating past either end.
// Clear and append give no result, except an append to a full table, which
// returns status 3. An evaluate searches the x memory segment by segment,
// then forms the product in a shift-add multiplier and divides it in a
// restoring divider. One item is in work at a time; a finished result waits
// in the output register until taken.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pli_pkg::out_item_t out_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = VW + 1;
  localparam int PW = 2 * RW;
  localparam int KW = $clog2(PW + 1);
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_FIRST, S_SCAN, S_FETCH, S_F0, S_F1,
    S_MUL, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t state_r;

  logic [CW-1:0]        count_r;
  logic signed [VW-1:0] q_r;
  logic signed [VW-1:0] xlast_r;
  logic signed [VW-1:0] prev_r;
  logic [AW-1:0]        idx_r;
  logic [AW-1:0]        seg_r;
  logic signed [VW-1:0] x0_r;
  logic signed [VW-1:0] y0_r;
  logic                 neg_r;
  logic [RW-1:0]        mplier_r;
  logic [RW-1:0]        mcand_r;
  logic [RW-1:0]        div_r;
  logic [PW-1:0]        acc_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        quot_r;
  logic [RW-1:0]        rem_r;
  logic [KW-1:0]        step_r;
  logic [VW-1:0]        pend_y_r;
  pli_pkg::status_t     pend_st_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  pli_pkg::out_item_t   out_data_r;

  logic                 we;
  logic [AW-1:0]        raddr;
  logic [VW-1:0]        x_rdata;
  logic [VW-1:0]        y_rdata;
  logic signed [VW-1:0] xd;
  logic signed [VW-1:0] yd;
  logic signed [VW-1:0] in_x;
  logic signed [VW-1:0] in_y;
  logic [AW-1:0]        cnt_m1;
  logic [AW-1:0]        last;
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] hi;
  logic                 hit;
  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;
  logic signed [RW-1:0] dd;
  logic [RW-1:0]        mag_dx;
  logic [RW-1:0]        mag_dy;
  logic [RW-1:0]        mag_dd;
  logic [PW-1:0]        acc_nxt;
  logic [RW:0]          trial;
  logic                 ge;
  logic [RW-1:0]        rem_nxt;
  logic                 over;
  logic signed [63:0]   qs;
  logic signed [63:0]   sum;

  assign in_x   = VW'($unsigned(in_data.x_value));
  assign in_y   = VW'($unsigned(in_data.y_value));
  assign xd     = $signed(x_rdata);
  assign yd     = $signed(y_rdata);
  assign cnt_m1 = AW'(count_r - CW'(1));
  assign last   = AW'(count_r - CW'(2));
  assign we     = (state_r == S_IDLE) && in_valid
                  && (in_data.operation == pli_pkg::OP_APPEND)
                  && (count_r < CW'(MAX_POINTS));

  assign lo  = (prev_r < xd) ? prev_r : xd;
  assign hi  = (prev_r < xd) ? xd : prev_r;
  assign hit = (q_r >= lo) && (q_r <= hi);

  assign dx     = RW'(q_r) - RW'(x0_r);
  assign dy     = RW'(yd) - RW'(y0_r);
  assign dd     = RW'(xd) - RW'(x0_r);
  assign mag_dx = dx[RW-1] ? RW'(-dx) : RW'(dx);
  assign mag_dy = dy[RW-1] ? RW'(-dy) : RW'(dy);
  assign mag_dd = dd[RW-1] ? RW'(-dd) : RW'(dd);

  assign acc_nxt = PW'({acc_r, 1'b0}) + (mplier_r[RW-1] ? PW'(mcand_r) : PW'(0));
  assign trial   = {rem_r, prod_r[PW-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign rem_nxt = ge ? RW'(trial - {1'b0, div_r}) : RW'(trial);

  assign over = (quot_r >> pli_pkg::QUOT_LIMIT_BITS) != '0;
  assign qs   = 64'(quot_r);
  assign sum  = 64'(y0_r) + (neg_r ? -qs : qs);

  assign out_valid_nxt = ((state_r == S_EMIT) && (!out_valid_r || !out_stall))
                         || (out_valid_r && out_stall);

  always_comb begin
    unique case (state_r)
      S_IDLE:  raddr = cnt_m1;
      S_LAST:  raddr = '0;
      S_FIRST: raddr = AW'(1);
      S_SCAN:  raddr = AW'(idx_r + AW'(1));
      S_FETCH: raddr = seg_r;
      S_F0:    raddr = AW'(seg_r + AW'(1));
      default: raddr = '0;
    endcase
  end

  pli_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_x),
    .raddr (raddr),
    .rdata (x_rdata)
  );

  pli_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_y),
    .raddr (raddr),
    .rdata (y_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.operation)
              pli_pkg::OP_CLEAR: count_r <= '0;
              pli_pkg::OP_APPEND: begin
                if (count_r < CW'(MAX_POINTS)) begin
                  count_r <= CW'(count_r + CW'(1));
                end else begin
                  pend_y_r  <= '0;
                  pend_st_r <= pli_pkg::ST_FULL;
                  state_r   <= S_EMIT;
                end
              end
              pli_pkg::OP_EVAL: begin
                q_r <= in_x;
                if (count_r < CW'(2)) begin
                  pend_y_r  <= '0;
                  pend_st_r <= pli_pkg::ST_TOO_FEW;
                  state_r   <= S_EMIT;
                end else begin
                  state_r <= S_LAST;
                end
              end
              default: ;
            endcase
          end
        end
        S_LAST: begin
          xlast_r <= xd;
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          if (q_r < xd) begin
            seg_r   <= '0;
            state_r <= S_FETCH;
          end else if (q_r > xlast_r) begin
            seg_r   <= last;
            state_r <= S_FETCH;
          end else begin
            prev_r  <= xd;
            idx_r   <= AW'(1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            seg_r   <= AW'(idx_r - AW'(1));
            state_r <= S_FETCH;
          end else if (idx_r == cnt_m1) begin
            seg_r   <= last;
            state_r <= S_FETCH;
          end else begin
            prev_r <= xd;
            idx_r  <= AW'(idx_r + AW'(1));
          end
        end
        S_FETCH: state_r <= S_F0;
        S_F0: begin
          x0_r    <= xd;
          y0_r    <= yd;
          state_r <= S_F1;
        end
        S_F1: begin
          if (xd == x0_r) begin
            pend_y_r  <= '0;
            pend_st_r <= pli_pkg::ST_ZERO_W;
            state_r   <= S_EMIT;
          end else begin
            neg_r    <= (dx[RW-1] ^ dy[RW-1]) ^ dd[RW-1];
            mplier_r <= mag_dx;
            mcand_r  <= mag_dy;
            div_r    <= mag_dd;
            acc_r    <= '0;
            step_r   <= KW'(RW);
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r    <= acc_nxt;
          mplier_r <= {mplier_r[RW-2:0], 1'b0};
          if (step_r == KW'(1)) begin
            prod_r  <= acc_nxt;
            rem_r   <= '0;
            quot_r  <= '0;
            step_r  <= KW'(PW);
            state_r <= S_DIV;
          end else begin
            step_r <= KW'(step_r - KW'(1));
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          prod_r <= {prod_r[PW-2:0], 1'b0};
          quot_r <= {quot_r[PW-2:0], ge};
          step_r <= KW'(step_r - KW'(1));
          if (step_r == KW'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          priority if (over) begin
            pend_y_r  <= neg_r ? VW'(VMIN) : VW'(VMAX);
            pend_st_r <= pli_pkg::ST_SATURATED;
          end else if (sum > VMAX) begin
            pend_y_r  <= VW'(VMAX);
            pend_st_r <= pli_pkg::ST_SATURATED;
          end else if (sum < VMIN) begin
            pend_y_r  <= VW'(VMIN);
            pend_st_r <= pli_pkg::ST_SATURATED;
          end else begin
            pend_y_r  <= VW'(sum);
            pend_st_r <= pli_pkg::ST_OK;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.y_result <= 32'(pend_y_r);
            out_data_r.status   <= pend_st_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/pli_checker.sv
`timescale 1ns / 1ps
module pli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pli_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pli_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= pli_pkg::ST_ZERO_W)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pli_pkg::ST_TOO_FEW
      || out_data.status == pli_pkg::ST_FULL
      || out_data.status == pli_pkg::ST_ZERO_W) |-> out_data.y_result == '0)
    else $error("error result carries a value");

  a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == pli_pkg::OP_EVAL |=> in_stall)
    else $error("input taken during evaluate");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/pli_checker.sv
`timescale 1ns / 1ps
module pli_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pli_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pli_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count,
  output int                 eval_count
);

  localparam int TABLE_DEPTH = 64;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  longint             bp_x[TABLE_DEPTH];
  longint             bp_y[TABLE_DEPTH];
  int                 bp_count;
  pli_pkg::out_item_t expected_results[$];

  function automatic pli_pkg::out_item_t result_of(logic [31:0] y, pli_pkg::status_t st);
    pli_pkg::out_item_t r;
    r.y_result = y;
    r.status   = st;
    return r;
  endfunction

  task automatic add_expected(pli_pkg::out_item_t r);
    expected_results = {expected_results, r};
  endtask

  function automatic pli_pkg::out_item_t interpolate(longint xq);
    int          seg, last;
    longint      x0, y0, x1, y1, dx, dy, dd, lo, hi, sum;
    logic [63:0] mdx, mdy, mdd;
    logic [127:0] prod, quot;
    bit          neg;
    last = bp_count - 2;
    if (xq < bp_x[0]) begin
      seg = 0;
    end else if (xq > bp_x[bp_count - 1]) begin
      seg = last;
    end else begin
      seg = last;
      for (int i = 0; i <= last; i++) begin
        lo = bp_x[i] < bp_x[i + 1] ? bp_x[i] : bp_x[i + 1];
        hi = bp_x[i] < bp_x[i + 1] ? bp_x[i + 1] : bp_x[i];
        if (xq >= lo && xq <= hi) begin
          seg = i;
          break;
        end
      end
    end
    x0 = bp_x[seg];
    y0 = bp_y[seg];
    x1 = bp_x[seg + 1];
    y1 = bp_y[seg + 1];
    if (x0 == x1) return result_of(32'd0, pli_pkg::ST_ZERO_W);
    dx = xq - x0;
    dy = y1 - y0;
    dd = x1 - x0;
    neg = ((dx < 0) != (dy < 0)) != (dd < 0);
    mdx = dx < 0 ? -dx : dx;
    mdy = dy < 0 ? -dy : dy;
    mdd = dd < 0 ? -dd : dd;
    prod = {64'd0, mdx} * {64'd0, mdy};
    quot = prod / {64'd0, mdd};
    if (quot >= (128'd1 << pli_pkg::QUOT_LIMIT_BITS))
      return result_of(neg ? 32'h8000_0000 : 32'h7fff_ffff, pli_pkg::ST_SATURATED);
    sum = neg ? y0 - longint'(quot[63:0]) : y0 + longint'(quot[63:0]);
    if (sum > Y_MAX) return result_of(32'h7fff_ffff, pli_pkg::ST_SATURATED);
    if (sum < Y_MIN) return result_of(32'h8000_0000, pli_pkg::ST_SATURATED);
    return result_of(sum[31:0], pli_pkg::ST_OK);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pli_pkg::out_item_t want;
    if (!rst_n) begin
      bp_count     = 0;
      fail_count   = 0;
      result_count = 0;
      eval_count   = 0;
      expected_results.delete();
      pending      = 0;
    end else begin
      if (in_valid && !in_stall) begin
        case (pli_pkg::op_t'(in_data.operation))
          pli_pkg::OP_CLEAR: bp_count = 0;
          pli_pkg::OP_APPEND: begin
            if (bp_count >= TABLE_DEPTH) begin
              add_expected(result_of(32'd0, pli_pkg::ST_FULL));
            end else begin
              bp_x[bp_count] = longint'(signed'(in_data.x_value));
              bp_y[bp_count] = longint'(signed'(in_data.y_value));
              bp_count++;
            end
          end
          pli_pkg::OP_EVAL: begin
            eval_count++;
            if (bp_count < 2)
              add_expected(result_of(32'd0, pli_pkg::ST_TOO_FEW));
            else
              add_expected(interpolate(longint'(signed'(in_data.x_value))));
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report("unexpected result", out_data.y_result, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.y_result !== want.y_result)
            report("y_result", out_data.y_result, want.y_result);
          if (out_data.status !== want.status)
            report("status", 32'(out_data.status), 32'(want.status));
        end
      end
      pending = expected_results.size();
    end
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int TOTAL_ITEMS   = 1200;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pli_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pli_pkg::out_item_t out_data;
  int                 fail_count, pending, result_count, eval_count;
  int                 sent = 0;
  int                 idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  piecewise_linear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pli_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .eval_count(eval_count)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bit fast_phase();
    return (sent / 150) % 4 == 3;
  endfunction

  task automatic send(pli_pkg::op_t op, logic [31:0] x, logic [31:0] y);
    int gap;
    gap = fast_phase() ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, x_value: x, y_value: y};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0000_0000;
           default: return 32'hffff_ffff;
         endcase
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  // receiver: random hold-offs, one long hold to back up the block
  initial begin
    int w;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      w = fast_phase() ? 0 : $urandom_range(0, 14);
      if (taken == 100) w = HOLD_CYCLES;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int n, m, k;
    int xs[$];
    logic [31:0] xq;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(pli_pkg::OP_EVAL, 32'h0001_0000, 32'd0);
    send(pli_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000);
    send(pli_pkg::OP_EVAL, 32'h0000_0000, 32'd0);
    send(pli_pkg::OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff);
    send(pli_pkg::OP_EVAL, 32'h8000_0000, 32'd0);
    send(pli_pkg::OP_EVAL, 32'h7fff_ffff, 32'd0);
    send(pli_pkg::OP_EVAL, 32'h0000_0000, 32'hffff_ffff);
    send(pli_pkg::OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
    send(pli_pkg::OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send(pli_pkg::OP_APPEND, 32'h0000_0000, 32'h7fff_ffff);
    send(pli_pkg::OP_APPEND, 32'h0000_0001, 32'h8000_0000);
    send(pli_pkg::OP_EVAL, 32'h7fff_ffff, 32'd0);
    send(pli_pkg::OP_EVAL, 32'h8000_0000, 32'd0);
    send(pli_pkg::OP_CLEAR, 32'd0, 32'd0);
    send(pli_pkg::OP_APPEND, 32'h0001_0000, 32'h0002_0000);
    send(pli_pkg::OP_APPEND, 32'h0001_0000, 32'h0005_0000);
    send(pli_pkg::OP_EVAL, 32'h0001_0000, 32'd0);
    send(pli_pkg::OP_APPEND, 32'hffff_0000, 32'h0003_0000);
    send(pli_pkg::OP_EVAL, 32'h0000_8000, 32'd0);
    send(pli_pkg::OP_EVAL, 32'h0005_0000, 32'd0);
    send(pli_pkg::OP_EVAL, 32'h8000_0000, 32'd0);

    while (sent < TOTAL_ITEMS) begin
      send(pli_pkg::OP_CLEAR, $urandom, $urandom);
      k = $urandom_range(0, 14);
      n = k == 0 ? 64 : (k == 1 ? $urandom_range(0, 1) : $urandom_range(2, 8));
      xs.delete();
      for (int i = 0; i < n; i++) xs = {xs, int'(rand_value())};
      if ($urandom_range(0, 7) != 0) xs.sort();
      if (n > 2 && $urandom_range(0, 9) == 0) xs[1] = xs[0];
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 30) == 0) send(pli_pkg::OP_NONE, $urandom, $urandom);
        if ($urandom_range(0, 40) == 0) send(pli_pkg::OP_EVAL, rand_value(), $urandom);
        send(pli_pkg::OP_APPEND, xs[i], rand_value());
      end
      if (n == 64) repeat ($urandom_range(1, 2)) send(pli_pkg::OP_APPEND, $urandom, $urandom);
      m = $urandom_range(3, 12);
      repeat (m) begin
        case ($urandom_range(0, 4))
          0: xq = rand_value();
          1: xq = n > 0 ? xs[$urandom_range(0, n - 1)] : $urandom;
          2: xq = n > 0 ? xs[0] - $urandom_range(0, 32'h0001_0000) : $urandom;
          3: xq = n > 0 ? xs[n - 1] + $urandom_range(0, 32'h0001_0000) : $urandom;
          default: xq = $urandom;
        endcase
        send(pli_pkg::OP_EVAL, xq, $urandom);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d items (%0d evaluations), checked %0d results",
             sent, eval_count, result_count);
    $display("covered clear, append, full table, too few points, zero width, extrapolation");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: piecewise_linear_interpolator.f
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/piecewise_linear_interpolator.sv
rtl/pli_checker.sv
sim/pli_checker.sv
sim/tb.sv
